@@ design/rda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_pkg
// Shared constants, codes and word types of the datagram ARQ core.
// ----------------------------------------------------------------------------
package rda_pkg;

	localparam int SEND_WINDOW   = 32;
	localparam int SW_W          = 5;
	localparam int REORDER_DEPTH = 32;
	localparam int RO_W          = 5;
	localparam int ACK_DEPTH     = 16;
	localparam int AQ_W          = 4;
	localparam int ACNT_W        = 5;
	localparam int MAX_RESULTS   = 64;
	localparam int RES_W         = 7;

	localparam logic [9:0]  TRIES_CAP       = 10'd1023;
	localparam logic [15:0] RTO_RESET       = 16'd40;
	localparam logic [9:0]  MAX_TRIES_RESET = 10'd1000;
	localparam logic [10:0] PMAX_RESET      = 11'd1390;

	// register indexes
	localparam logic [1:0] REG_RTO  = 2'd0;
	localparam logic [1:0] REG_TRY  = 2'd1;
	localparam logic [1:0] REG_PMAX = 2'd2;

	// request codes
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_ACK  = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// result kinds
	localparam logic [2:0] K_QUEUED = 3'd0;
	localparam logic [2:0] K_SENT   = 3'd1;
	localparam logic [2:0] K_ACK    = 3'd2;
	localparam logic [2:0] K_DLVR   = 3'd3;
	localparam logic [2:0] K_REJECT = 3'd4;
	localparam logic [2:0] K_DROP   = 3'd5;

	// classified request: a holds the one 32-bit argument of the request
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] a;
		logic [15:0] seg;
		logic [10:0] len;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] seq;
		logic [31:0] ack_seq;
		logic [10:0] length;
		logic [15:0] segment;
	} res_t;

	typedef struct packed {
		logic [15:0] rto;
		logic [9:0]  max_tries;
		logic [10:0] payload_max;
	} cfg_t;

endpackage

@@ design/rda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_front
// Input stage: takes request words and reduces them to one command word.
// ----------------------------------------------------------------------------
module rda_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [15:0]      message_length,
	input  logic [31:0]      rx_seq,
	input  logic [15:0]      rx_segment,
	input  logic [10:0]      rx_length,
	input  logic [31:0]      rx_ack_seq,
	input  logic [31:0]      now,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output rda_pkg::cmd_t    cmd
);

	logic          hold_q;
	rda_pkg::cmd_t cmd_q;
	rda_pkg::cmd_t cls;

	always_comb begin
		cls     = '0;
		cls.op  = req_type;
		case (req_type)
			rda_pkg::OP_SEND: cls.a = {16'd0, message_length};
			rda_pkg::OP_DATA: begin
				cls.a   = rx_seq;
				cls.seg = rx_segment;
				cls.len = rx_length;
			end
			rda_pkg::OP_ACK:  cls.a = rx_ack_seq;
			default:          cls.a = now;
		endcase
	end

	assign in_ready  = !hold_q || cmd_ready;
	assign cmd_valid = hold_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_ready) begin
			hold_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= cls;
		end
	end

endmodule

@@ design/rda_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_queue
// Two-entry command queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module rda_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rda_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output rda_pkg::cmd_t pop_cmd
);

	rda_pkg::cmd_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          wr;
	logic          rd;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = mem_q[rp_q];
	assign wr         = push_valid && push_ready;
	assign rd         = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

endmodule

@@ design/rda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_back
// Sequencer: runs one command against the send, reorder and ack tables.
// ----------------------------------------------------------------------------
module rda_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rda_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  rda_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output rda_pkg::res_t out_res,
	output logic          out_last
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SPREP = 4'd1;
	localparam logic [3:0] ST_SDEC  = 4'd2;
	localparam logic [3:0] ST_SFRAG = 4'd3;
	localparam logic [3:0] ST_DCLS  = 4'd4;
	localparam logic [3:0] ST_DDROP = 4'd5;
	localparam logic [3:0] ST_DDLV  = 4'd6;
	localparam logic [3:0] ST_ASCAN = 4'd7;
	localparam logic [3:0] ST_AEND  = 4'd8;
	localparam logic [3:0] ST_TACK  = 4'd9;
	localparam logic [3:0] ST_TSCAN = 4'd10;
	localparam logic [3:0] ST_FLUSH = 4'd11;

	localparam logic [rda_pkg::SW_W-1:0] IDX_LAST = '1;

	logic [3:0]                      st_q;
	rda_pkg::cmd_t                   cmd_q;
	logic [rda_pkg::SW_W-1:0]        idx_q;
	logic [rda_pkg::RES_W-1:0]       n_q;
	logic [5:0]                      free_q;
	logic [5:0]                      k_q;
	logic [15:0]                     quo_q;
	logic [15:0]                     dvd_q;
	logic [11:0]                     rem_q;
	logic [15:0]                     count_q;
	logic [15:0]                     left_q;
	logic                            hit_q;

	logic [31:0]                     next_seq_q;
	logic [31:0]                     expect_seq_q;
	logic [rda_pkg::RO_W-1:0]        head_q;
	logic [rda_pkg::ACNT_W-1:0]      ack_count_q;
	logic [rda_pkg::SEND_WINDOW-1:0] send_valid_q;
	logic [rda_pkg::REORDER_DEPTH-1:0] reorder_valid_q;

	logic [31:0] send_seq_q     [rda_pkg::SEND_WINDOW];
	logic [10:0] send_len_q     [rda_pkg::SEND_WINDOW];
	logic [15:0] send_segment_q [rda_pkg::SEND_WINDOW];
	logic [9:0]  send_tries_q   [rda_pkg::SEND_WINDOW];
	logic [31:0] send_time_q    [rda_pkg::SEND_WINDOW];
	logic [10:0] reorder_len_q     [rda_pkg::REORDER_DEPTH];
	logic [15:0] reorder_segment_q [rda_pkg::REORDER_DEPTH];
	logic [31:0] ack_queue_seq_q   [rda_pkg::ACK_DEPTH];

	logic          pend_v_q;
	rda_pkg::res_t pend_q;
	logic          out_v_q;
	rda_pkg::res_t out_q;
	logic          out_last_q;

	logic          out_free;
	logic          can_prod;
	logic          out_load;
	logic          prod;
	rda_pkg::res_t prod_r;
	logic [10:0]   pm_eff;
	logic [10:0]   frag_len;
	logic [11:0]   rem_sh;
	logic          rem_ge;
	logic [15:0]   count_c;
	logic          cur_valid;
	logic [31:0]   age;
	logic          go;
	logic [31:0]   off;
	logic [31:0]   bk;
	logic          in_win;
	logic [rda_pkg::RO_W-1:0] slot;
	logic          ack_room;
	logic          alloc;
	logic          tsend;
	logic          apush;
	logic          rstore;
	logic          dlv;
	logic          budget_left;

	assign out_free    = !out_v_q || out_ready;
	assign can_prod    = !pend_v_q || out_free;
	// held word moves on when a new one replaces it or at the end of the command
	assign out_load    = pend_v_q && (prod || (st_q == ST_FLUSH && out_free));
	assign pm_eff      = (cfg.payload_max == 11'd0) ? 11'd1 : cfg.payload_max;
	assign frag_len    = (left_q > {5'd0, pm_eff}) ? pm_eff : left_q[10:0];
	assign rem_sh      = {rem_q[10:0], dvd_q[15]};
	assign rem_ge      = rem_sh >= {1'b0, pm_eff};
	assign count_c     = quo_q + {15'd0, rem_q != 12'd0};
	assign cur_valid   = send_valid_q[idx_q];
	assign age         = cmd_q.a - send_time_q[idx_q];
	assign go          = (send_tries_q[idx_q] == 10'd0) ||
		((send_tries_q[idx_q] <= cfg.max_tries) && (age > {16'd0, cfg.rto}));
	assign off         = cmd_q.a - expect_seq_q;
	assign bk          = expect_seq_q - cmd_q.a;
	assign in_win      = off < 32'(rda_pkg::REORDER_DEPTH);
	assign slot        = head_q + off[rda_pkg::RO_W-1:0];
	assign ack_room    = ack_count_q < rda_pkg::ACNT_W'(rda_pkg::ACK_DEPTH);
	assign budget_left = n_q != rda_pkg::RES_W'(rda_pkg::MAX_RESULTS);

	assign alloc  = (st_q == ST_SFRAG) && !cur_valid && can_prod;
	assign tsend  = (st_q == ST_TSCAN) && budget_left && cur_valid && go && can_prod;
	assign apush  = (st_q == ST_DCLS) && ack_room &&
		(in_win || (bk <= 32'(rda_pkg::REORDER_DEPTH)));
	assign rstore = (st_q == ST_DCLS) && in_win && ack_room && !reorder_valid_q[slot];
	assign dlv    = (st_q == ST_DDLV) && budget_left && reorder_valid_q[head_q] && can_prod;
	assign cmd_pop = (st_q == ST_IDLE) && cmd_valid;

	always_comb begin
		prod   = 1'b0;
		prod_r = '0;
		case (st_q)
			ST_SDEC: begin
				if (count_c != 16'd0 && count_c > {10'd0, free_q}) begin
					prod           = can_prod;
					prod_r.kind    = rda_pkg::K_REJECT;
					prod_r.seq     = next_seq_q;
					prod_r.segment = count_c;
				end
			end
			ST_SFRAG: begin
				prod           = alloc;
				prod_r.kind    = rda_pkg::K_QUEUED;
				prod_r.seq     = next_seq_q;
				prod_r.length  = frag_len;
				prod_r.segment = count_q - 16'd1 - {10'd0, k_q};
			end
			ST_DDROP: begin
				prod           = can_prod;
				prod_r.kind    = rda_pkg::K_DROP;
				prod_r.seq     = cmd_q.a;
				prod_r.length  = cmd_q.len;
				prod_r.segment = cmd_q.seg;
			end
			ST_DDLV: begin
				prod           = dlv;
				prod_r.kind    = rda_pkg::K_DLVR;
				prod_r.seq     = expect_seq_q;
				prod_r.length  = reorder_len_q[head_q];
				prod_r.segment = reorder_segment_q[head_q];
			end
			ST_AEND: begin
				prod        = !hit_q && can_prod;
				prod_r.kind = rda_pkg::K_DROP;
				prod_r.seq  = cmd_q.a;
			end
			ST_TACK: begin
				prod           = (k_q[rda_pkg::ACNT_W-1:0] != ack_count_q) && can_prod;
				prod_r.kind    = rda_pkg::K_ACK;
				prod_r.ack_seq = ack_queue_seq_q[k_q[rda_pkg::AQ_W-1:0]];
			end
			ST_TSCAN: begin
				prod           = tsend;
				prod_r.kind    = rda_pkg::K_SENT;
				prod_r.seq     = send_seq_q[idx_q];
				prod_r.length  = send_len_q[idx_q];
				prod_r.segment = send_segment_q[idx_q];
			end
			default: begin
				prod = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ST_IDLE;
			pend_v_q        <= 1'b0;
			out_v_q         <= 1'b0;
			next_seq_q      <= '0;
			expect_seq_q    <= '0;
			head_q          <= '0;
			ack_count_q     <= '0;
			send_valid_q    <= '0;
			reorder_valid_q <= '0;
		end else begin
			out_v_q  <= out_load || (out_v_q && !out_ready);
			pend_v_q <= prod || (pend_v_q && !out_load);
			if (alloc) begin
				send_valid_q[idx_q] <= 1'b1;
				next_seq_q          <= next_seq_q + 32'd1;
			end
			if (apush) ack_count_q <= ack_count_q + 1'b1;
			if (rstore) reorder_valid_q[slot] <= 1'b1;
			if (dlv) begin
				reorder_valid_q[head_q] <= 1'b0;
				head_q                  <= head_q + 1'b1;
				expect_seq_q            <= expect_seq_q + 32'd1;
			end
			if (st_q == ST_ASCAN && cur_valid && send_seq_q[idx_q] == cmd_q.a) begin
				send_valid_q[idx_q] <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							rda_pkg::OP_SEND: st_q <= ST_SPREP;
							rda_pkg::OP_DATA: st_q <= ST_DCLS;
							rda_pkg::OP_ACK:  st_q <= ST_ASCAN;
							default:          st_q <= ST_TACK;
						endcase
					end
				end
				ST_SPREP: if (idx_q == IDX_LAST) st_q <= ST_SDEC;
				ST_SDEC: begin
					if (count_c == 16'd0) st_q <= ST_FLUSH;
					else if (count_c > {10'd0, free_q}) begin
						if (can_prod) st_q <= ST_FLUSH;
					end else st_q <= ST_SFRAG;
				end
				ST_SFRAG: begin
					if (alloc && (k_q + 6'd1 == count_q[5:0])) st_q <= ST_FLUSH;
				end
				ST_DCLS: st_q <= (!in_win || !ack_room) ? ST_DDROP : ST_DDLV;
				ST_DDROP: if (can_prod) st_q <= ST_DDLV;
				ST_DDLV: begin
					if (!budget_left || !reorder_valid_q[head_q]) st_q <= ST_FLUSH;
				end
				ST_ASCAN: if (idx_q == IDX_LAST) st_q <= ST_AEND;
				ST_AEND: if (hit_q || can_prod) st_q <= ST_FLUSH;
				ST_TACK: begin
					if (k_q[rda_pkg::ACNT_W-1:0] == ack_count_q) begin
						ack_count_q <= '0;
						st_q        <= ST_TSCAN;
					end
				end
				ST_TSCAN: begin
					if (!budget_left) st_q <= ST_FLUSH;
					else if ((!cur_valid || !go || can_prod) && idx_q == IDX_LAST)
						st_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and tables
	always_ff @(posedge clk) begin
		if (prod) begin
			pend_q <= prod_r;
		end
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= (st_q == ST_FLUSH);
		end
		case (st_q)
			ST_IDLE: begin
				cmd_q  <= cmd;
				n_q    <= '0;
				idx_q  <= '0;
				free_q <= '0;
				k_q    <= '0;
				quo_q  <= '0;
				rem_q  <= '0;
				hit_q  <= 1'b0;
				dvd_q  <= cmd.a[15:0];
				left_q <= cmd.a[15:0];
			end
			ST_SPREP: begin
				// one divide step per cycle in the first half, free count throughout
				free_q <= free_q + {5'd0, !cur_valid};
				idx_q  <= idx_q + 1'b1;
				if (!idx_q[rda_pkg::SW_W-1]) begin
					dvd_q <= {dvd_q[14:0], 1'b0};
					quo_q <= {quo_q[14:0], rem_ge};
					rem_q <= rem_ge ? (rem_sh - {1'b0, pm_eff}) : rem_sh;
				end
			end
			ST_SDEC: begin
				count_q <= count_c;
				idx_q   <= '0;
			end
			ST_SFRAG: begin
				if (cur_valid) idx_q <= idx_q + 1'b1;
				if (alloc) begin
					send_seq_q[idx_q]     <= next_seq_q;
					send_len_q[idx_q]     <= frag_len;
					send_segment_q[idx_q] <= prod_r.segment;
					send_tries_q[idx_q]   <= 10'd0;
					send_time_q[idx_q]    <= 32'd0;
					left_q                <= left_q - {5'd0, frag_len};
					k_q                   <= k_q + 6'd1;
					idx_q                 <= idx_q + 1'b1;
				end
			end
			ST_DCLS: begin
				if (apush) ack_queue_seq_q[ack_count_q[rda_pkg::AQ_W-1:0]] <= cmd_q.a;
				if (rstore) begin
					reorder_len_q[slot]     <= cmd_q.len;
					reorder_segment_q[slot] <= cmd_q.seg;
				end
			end
			ST_ASCAN: begin
				if (cur_valid && send_seq_q[idx_q] == cmd_q.a) hit_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
			end
			ST_TACK: begin
				if (prod) k_q <= k_q + 6'd1;
				idx_q <= '0;
			end
			ST_TSCAN: begin
				if (tsend) begin
					if (send_tries_q[idx_q] < rda_pkg::TRIES_CAP)
						send_tries_q[idx_q] <= send_tries_q[idx_q] + 10'd1;
					send_time_q[idx_q] <= cmd_q.a;
				end
				if (!cur_valid || !go || can_prod) idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (prod) n_q <= n_q + 1'b1;
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

@@ design/reliable_datagram_arq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_datagram_arq_core
// Selective-repeat ARQ on segment headers: fragmenting, acking, reordering.
// ----------------------------------------------------------------------------
// Path: a request word passes the front register and the queue before the
// sequencer takes it. Send: free-entry count over all 32 send entries with a
// 16-step divide, decision, allocation scanning the send table, flush. Data:
// classify, in-order delivery, flush. Ack: send table compared one entry a
// cycle. Tick: queued acks, then resend scan. Output stalls hold. One at a time.
// Reset (arst_n low): tables empty, sequence numbers zero, registers defaulted.
// ----------------------------------------------------------------------------
module reliable_datagram_arq_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	// request words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] message_length,
	input  logic [31:0] rx_seq,
	input  logic [15:0] rx_segment,
	input  logic [10:0] rx_length,
	input  logic [31:0] rx_ack_seq,
	input  logic [31:0] now,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] seq,
	output logic [31:0] ack_seq,
	output logic [10:0] length,
	output logic [15:0] segment,
	output logic        last
);

	rda_pkg::cfg_t cfg_q;
	rda_pkg::cmd_t f_cmd;
	rda_pkg::cmd_t q_cmd;
	rda_pkg::res_t res;
	logic          f_valid;
	logic          f_ready;
	logic          q_valid;
	logic          q_pop;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto         <= rda_pkg::RTO_RESET;
			cfg_q.max_tries   <= rda_pkg::MAX_TRIES_RESET;
			cfg_q.payload_max <= rda_pkg::PMAX_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				rda_pkg::REG_RTO:  cfg_q.rto         <= cfg_wdata;
				rda_pkg::REG_TRY:  cfg_q.max_tries   <= cfg_wdata[9:0];
				rda_pkg::REG_PMAX: cfg_q.payload_max <= cfg_wdata[10:0];
				default:           cfg_q             <= cfg_q;
			endcase
		end
	end

	// front: registers the request word and keeps only the fields its type uses
	rda_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.message_length (message_length),
		.rx_seq         (rx_seq),
		.rx_segment     (rx_segment),
		.rx_length      (rx_length),
		.rx_ack_seq     (rx_ack_seq),
		.now            (now),
		.cmd_valid      (f_valid),
		.cmd_ready      (f_ready),
		.cmd            (f_cmd)
	);

	// short queue so the front keeps taking words while the sequencer is busy
	rda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	// sequencer: owns all tables, one result held back so the final one is flagged
	rda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (last)
	);

	assign kind    = res.kind;
	assign seq     = res.seq;
	assign ack_seq = res.ack_seq;
	assign length  = res.length;
	assign segment = res.segment;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the datagram ARQ core. An in-bench model of the
// send table, reorder window and ack queue predicts every result word. The
// bench runs directed requests and then random phases with idling on both
// sides. Results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rda_pkg::*;

	typedef struct {
		res_t r;
		logic last;
	} arq_exp_t;

	// predicts result words and checks them in order
	class arq_scoreboard;
		logic [15:0] rto;
		logic [9:0]  max_tries;
		logic [10:0] pmax;
		logic [31:0] next_seq, expect_seq;
		bit          tx_busy [SEND_WINDOW];
		logic [31:0] tx_seq  [SEND_WINDOW];
		logic [10:0] tx_len  [SEND_WINDOW];
		logic [15:0] tx_seg  [SEND_WINDOW];
		logic [9:0]  tx_tries[SEND_WINDOW];
		logic [31:0] tx_time [SEND_WINDOW];
		bit          ro_busy [REORDER_DEPTH];
		logic [10:0] ro_len  [REORDER_DEPTH];
		logic [15:0] ro_seg  [REORDER_DEPTH];
		int          ro_head;
		logic [31:0] ackq[ACK_DEPTH];
		int          ack_cnt;
		arq_exp_t    pending[$];
		int          errors;

		function new();
			rto = RTO_RESET;
			max_tries = MAX_TRIES_RESET;
			pmax = PMAX_RESET;
			next_seq = 0;
			expect_seq = 0;
			ro_head = 0;
			ack_cnt = 0;
			errors = 0;
			foreach (tx_busy[i]) tx_busy[i] = 0;
			foreach (ro_busy[i]) ro_busy[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] v);
			case (idx)
				REG_RTO:  rto = v;
				REG_TRY:  max_tries = v[9:0];
				REG_PMAX: pmax = v[10:0];
				default: ;
			endcase
		endfunction

		function void add(logic [2:0] k, logic [31:0] s, logic [31:0] a,
			logic [10:0] l, logic [15:0] g);
			arq_exp_t e;
			e.r.kind = k;
			e.r.seq = s;
			e.r.ack_seq = a;
			e.r.length = l;
			e.r.segment = g;
			e.last = 0;
			pending.insert(pending.size(), e);
		endfunction

		function void note_input(logic [1:0] op, logic [15:0] mlen, logic [31:0] rseq,
			logic [15:0] rseg, logic [10:0] rlen, logic [31:0] aseq, logic [31:0] tnow);
			int n0, cnt, nfree, pm, left, fl, slot;
			logic [31:0] off, back;
			bit hit, go;
			n0 = pending.size();
			case (op)
				OP_SEND: begin
					pm = (pmax == 0) ? 1 : pmax;
					cnt = (mlen + pm - 1) / pm;
					nfree = 0;
					foreach (tx_busy[i]) if (!tx_busy[i]) nfree++;
					left = mlen;
					if (cnt > nfree) begin
						add(K_REJECT, next_seq, 0, 0, cnt[15:0]);
					end else begin
						for (int k = 0; k < cnt; k++) begin
							fl = (left > pm) ? pm : left;
							slot = 0;
							while (tx_busy[slot]) slot++;
							tx_busy[slot] = 1;
							tx_seq[slot] = next_seq;
							tx_len[slot] = fl;
							tx_seg[slot] = cnt - k - 1;
							tx_tries[slot] = 0;
							tx_time[slot] = 0;
							add(K_QUEUED, next_seq, 0, fl, cnt - k - 1);
							next_seq++;
							left -= fl;
						end
					end
				end
				OP_DATA: begin
					off = rseq - expect_seq;
					back = expect_seq - rseq;
					if (off < REORDER_DEPTH) begin
						if (ack_cnt >= ACK_DEPTH) begin
							add(K_DROP, rseq, 0, rlen, rseg);
						end else begin
							slot = (ro_head + off) % REORDER_DEPTH;
							ackq[ack_cnt++] = rseq;
							if (!ro_busy[slot]) begin
								ro_busy[slot] = 1;
								ro_len[slot] = rlen;
								ro_seg[slot] = rseg;
							end
						end
					end else begin
						if (back <= REORDER_DEPTH && ack_cnt < ACK_DEPTH)
							ackq[ack_cnt++] = rseq;
						add(K_DROP, rseq, 0, rlen, rseg);
					end
					while (pending.size() - n0 < MAX_RESULTS && ro_busy[ro_head]) begin
						add(K_DLVR, expect_seq, 0, ro_len[ro_head], ro_seg[ro_head]);
						ro_busy[ro_head] = 0;
						ro_head = (ro_head + 1) % REORDER_DEPTH;
						expect_seq++;
					end
				end
				OP_ACK: begin
					hit = 0;
					foreach (tx_busy[i]) begin
						if (tx_busy[i] && tx_seq[i] == aseq) begin
							tx_busy[i] = 0;
							hit = 1;
						end
					end
					if (!hit)
						add(K_DROP, aseq, 0, 0, 0);
				end
				default: begin
					for (int k = 0; k < ack_cnt; k++)
						add(K_ACK, 0, ackq[k], 0, 0);
					ack_cnt = 0;
					for (int i = 0; i < SEND_WINDOW && pending.size() - n0 < MAX_RESULTS;
						i++) begin
						if (!tx_busy[i])
							continue;
						if (tx_tries[i] == 0)
							go = 1;
						else if (tx_tries[i] > max_tries)
							go = 0;
						else
							go = (tnow - tx_time[i]) > {16'd0, rto};
						if (go) begin
							add(K_SENT, tx_seq[i], 0, tx_len[i], tx_seg[i]);
							if (tx_tries[i] < TRIES_CAP)
								tx_tries[i]++;
							tx_time[i] = tnow;
						end
					end
				end
			endcase
			if (pending.size() > n0)
				pending[pending.size() - 1].last = 1;
		endfunction

		function void check_result(res_t r, logic last);
			arq_exp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: kind %0d seq %h", r.kind, r.seq);
				return;
			end
			e = pending.pop_front();
			if (r !== e.r || last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp k%0d s%h a%h l%0d g%0d L%0d, got k%0d s%h a%h l%0d g%0d L%0d",
						e.r.kind, e.r.seq, e.r.ack_seq, e.r.length, e.r.segment, e.last,
						r.kind, r.seq, r.ack_seq, r.length, r.segment, last);
			end
		endfunction
	endclass

	localparam int WDOG_LIMIT = 5000;
	localparam int SETTLE     = 200;	// covers silent requests still queued in the core

	logic        clk = 0;
	logic        arst_n;
	logic        cfg_wen;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;
	logic        in_valid, in_ready;
	logic [1:0]  req_type;
	logic [15:0] message_length;
	logic [31:0] rx_seq, rx_ack_seq, now;
	logic [15:0] rx_segment;
	logic [10:0] rx_length;
	logic        out_valid, out_ready;
	logic [2:0]  kind;
	logic [31:0] seq, ack_seq;
	logic [10:0] length;
	logic [15:0] segment;
	logic        last;

	arq_scoreboard sb;
	int          idle_pct, stall_pct, quiet;
	logic [31:0] tick_time;

	reliable_datagram_arq_core DUT (.*);

	always #2 clk = ~clk;

	// result side: check every accepted word, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{kind, seq, ack_seq, length, segment}, last);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one request word; valid stays high afterwards until the next call or drain
	task automatic issue(logic [1:0] op, logic [15:0] ml, logic [31:0] rs,
		logic [15:0] rg, logic [10:0] rl, logic [31:0] ra, logic [31:0] tn);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid       <= 1;
		req_type       <= op;
		message_length <= ml;
		rx_seq         <= rs;
		rx_segment     <= rg;
		rx_length      <= rl;
		rx_ack_seq     <= ra;
		now            <= tn;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, ml, rs, rg, rl, ra, tn);
	endtask

	// unused fields get noise so that the block must ignore them
	task automatic send_msg(logic [15:0] ml);
		issue(OP_SEND, ml, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic rx_data(logic [31:0] rs, logic [15:0] rg, logic [10:0] rl);
		issue(OP_DATA, $urandom, rs, rg, rl, $urandom, $urandom);
	endtask

	task automatic rx_ack(logic [31:0] ra);
		issue(OP_ACK, $urandom, $urandom, $urandom, $urandom, ra, $urandom);
	endtask

	task automatic tick(logic [31:0] tn);
		issue(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, tn);
	endtask

	// stop sending, wait for all expected words, then let the core settle
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		cfg_wen   <= 1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 0;
		sb.set_reg(idx, v);
	endtask

	task automatic rand_item();
		int r, pm;
		r = $urandom_range(99);
		pm = (sb.pmax == 0) ? 1 : sb.pmax;
		if (r < 22) begin
			if ($urandom_range(19) == 0)
				send_msg($urandom);
			else
				send_msg($urandom_range(0, (pm * 3 > 65535) ? 65535 : pm * 3));
		end else if (r < 50) begin
			r = $urandom_range(99);
			if (r < 70)
				rx_data(sb.expect_seq + $urandom_range(0, 34),
					($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), $urandom);
			else if (r < 85)
				rx_data(sb.expect_seq - $urandom_range(1, 40), $urandom, $urandom);
			else
				rx_data($urandom, $urandom, $urandom);
		end else if (r < 72) begin
			if ($urandom_range(4) == 0)
				rx_ack($urandom);
			else
				rx_ack(sb.next_seq - $urandom_range(1, 40));
		end else begin
			if ($urandom_range(19) == 0)
				tick_time += $urandom;
			else
				tick_time += $urandom_range(0, 80);
			tick(tick_time);
		end
	endtask

	task automatic run_phase(int idle, int stall, int items,
		logic [15:0] r_to, logic [9:0] r_try, logic [10:0] r_pm, bit pause);
		drain();
		write_reg(REG_RTO, r_to);
		write_reg(REG_TRY, r_try);
		write_reg(REG_PMAX, r_pm);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++) begin
			// hold off once mid-phase until the core has caught up
			if (pause && i == items / 2)
				drain();
			rand_item();
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		quiet = 0;
		tick_time = 0;
		arst_n <= 0;
		cfg_wen <= 0;
		cfg_idx <= REG_RTO;
		cfg_wdata <= 0;
		in_valid <= 0;
		req_type <= OP_SEND;
		message_length <= 0;
		rx_seq <= 0;
		rx_segment <= 0;
		rx_length <= 0;
		rx_ack_seq <= 0;
		now <= 0;
		out_ready <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part at reset defaults
		send_msg(0);			// empty message
		send_msg(16'hFFFF);		// more fragments than the table holds
		send_msg(3000);			// three fragments
		tick(0);			// first transmissions
		rx_ack(1);
		rx_ack(32'hFFFF_FFFF);		// unknown ack
		rx_data(1, 0, 11'h7FF);		// out of order, held back
		rx_data(0, 16'hFFFF, 0);	// releases both
		rx_data(0, 5, 7);		// old duplicate
		rx_data(40, 1, 2);		// ahead of the window
		tick(50);			// acks plus resends after rto
		for (int k = 0; k < 17; k++)	// fills the ack queue, last one dropped
			rx_data(2 + k, k, k);
		rx_data(3, 9, 9);		// old duplicate, ack queue full
		tick(32'hFFFF_FFF0);
		drain();
		write_reg(REG_PMAX, 0);		// zero payload size acts as one byte
		send_msg(3);
		send_msg(40);			// table too full
		tick(32'h0000_0020);		// age wraps past zero

		// random phases through several register settings
		tick_time = 32'h0000_0100;
		run_phase(0, 0, 25, 16'd0, 10'd0, 11'd1, 0);
		run_phase(47, 0, 25, 16'hFFFF, 10'd1023, 11'd2047, 0);
		tick_time = 32'hFFFF_FF80;
		run_phase(0, 47, 25, 16'd20, 10'd3, 11'd100, 1);
		run_phase(29, 29, 25, 16'd10, 10'd1023, 11'd500, 0);
		drain();

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ reliable_datagram_arq_core.f @@
design/rda_pkg.sv
design/rda_front.sv
design/rda_queue.sv
design/rda_back.sv
design/reliable_datagram_arq_core.sv
bench/tb_top.sv
